@@ rtl/srsw_pkg.sv @@
// Shared types and constants for the selective-repeat sender window.
`timescale 1ns / 1ps
package srsw_pkg;

   localparam int SEQ_W      = 3;
   localparam int MAX_WINDOW = 4;
   localparam int OFF_W      = 2;
   localparam int CNT_W      = 3;
   localparam int WS_W       = 3;

   localparam logic [WS_W-1:0] WINDOW_SIZE_RESET = 3'd3;

   localparam logic [1:0] FUNC_SEND    = 2'd0;
   localparam logic [1:0] FUNC_ACK     = 2'd1;
   localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

   localparam logic [2:0] ACT_REFUSED    = 3'd0;
   localparam logic [2:0] ACT_TRANSMIT   = 3'd1;
   localparam logic [2:0] ACT_ACK_TAKEN  = 3'd2;
   localparam logic [2:0] ACT_ACK_IGNORE = 3'd3;
   localparam logic [2:0] ACT_RETRANSMIT = 3'd4;
   localparam logic [2:0] ACT_TIMEOUT_ERR = 3'd5;

   typedef struct packed {
      logic [1:0]       func;
      logic [SEQ_W-1:0] seq_num;
      logic             checksum_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]       action;
      logic [SEQ_W-1:0] seq_out;
      logic             timer_start;
      logic             timer_stop;
      logic [CNT_W-1:0] slots_freed;
      logic             window_full;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

@@ rtl/srsw_ctrl.sv @@
// Controller for the sender window: sequences capture and commit of each event.
`timescale 1ns / 1ps
module srsw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output srsw_pkg::cmd_type cmd
);
   import srsw_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   always_comb begin
      out_free    = !rsp_valid_ff || rsp_ready;
      req_ready   = (state_ff == ST_IDLE);
      cmd.capture = req_valid && req_ready;
      cmd.commit  = (state_ff == ST_EXEC) && out_free;

      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cmd.commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // A committed result replaces any one being taken in the same cycle.
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/srsw_dpath.sv @@
// Datapath for the sender window: window state, event evaluation and result register.
`timescale 1ns / 1ps
module srsw_dpath (
   input  logic              clock,
   input  logic              reset,
   input  srsw_pkg::cmd_type cmd,
   input  srsw_pkg::req_type req_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_wdata,
   output srsw_pkg::rsp_type rsp_data
);
   import srsw_pkg::*;

   req_type              req_ff;
   rsp_type              rsp_ff, rsp_in;
   logic [WS_W-1:0]      window_size_ff;
   logic [SEQ_W-1:0]     base_ff, base_in;
   logic [SEQ_W-1:0]     next_seq_ff, next_seq_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [MAX_WINDOW-1:0] marks_ff, marks_in;

   logic [WS_W-1:0]       eff_window;
   logic [SEQ_W-1:0]      offset;
   logic                  in_window;
   logic [MAX_WINDOW-1:0] marks_set;
   logic [CNT_W-1:0]      slide;
   logic                  run;

   always_comb begin
      if (window_size_ff == '0) begin
         eff_window = WS_W'(1);
      end else if (window_size_ff > WS_W'(MAX_WINDOW)) begin
         eff_window = WS_W'(MAX_WINDOW);
      end else begin
         eff_window = window_size_ff;
      end

      // Offset from the window base wraps naturally in the sequence width.
      offset    = req_ff.seq_num - base_ff;
      in_window = (CNT_W'(offset) < count_ff) && (offset < SEQ_W'(MAX_WINDOW));
      marks_set = marks_ff | (MAX_WINDOW'(1) << offset[OFF_W-1:0]);

      // Count leading acknowledged slots among the outstanding ones.
      slide = '0;
      run   = 1'b1;
      for (int k = 0; k < MAX_WINDOW; k++) begin
         if (run && (CNT_W'(k) < count_ff) && marks_set[k]) begin
            slide = slide + CNT_W'(1);
         end else begin
            run = 1'b0;
         end
      end

      base_in     = base_ff;
      next_seq_in = next_seq_ff;
      count_in    = count_ff;
      marks_in    = marks_ff;

      rsp_in.action      = ACT_ACK_IGNORE;
      rsp_in.seq_out     = req_ff.seq_num;
      rsp_in.timer_start = 1'b0;
      rsp_in.timer_stop  = 1'b0;
      rsp_in.slots_freed = '0;

      unique case (req_ff.func)
         FUNC_SEND: begin
            rsp_in.seq_out = next_seq_ff;
            if (count_ff >= eff_window) begin
               rsp_in.action = ACT_REFUSED;
            end else begin
               rsp_in.action      = ACT_TRANSMIT;
               rsp_in.timer_start = 1'b1;
               next_seq_in        = next_seq_ff + SEQ_W'(1);
               count_in           = count_ff + CNT_W'(1);
            end
         end
         FUNC_ACK: begin
            if (req_ff.checksum_ok && in_window) begin
               rsp_in.action      = ACT_ACK_TAKEN;
               rsp_in.timer_stop  = 1'b1;
               rsp_in.slots_freed = slide;
               marks_in           = marks_set >> slide;
               base_in            = base_ff + SEQ_W'(slide);
               count_in           = count_ff - slide;
            end
         end
         FUNC_TIMEOUT: begin
            rsp_in.timer_stop = 1'b1;
            if (in_window) begin
               rsp_in.action      = ACT_RETRANSMIT;
               rsp_in.timer_start = 1'b1;
            end else begin
               rsp_in.action = ACT_TIMEOUT_ERR;
            end
         end
         default: begin
            rsp_in.action = ACT_ACK_IGNORE;
         end
      endcase

      rsp_in.window_full = (count_in >= eff_window);
   end

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.commit)  rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
         base_ff        <= '0;
         next_seq_ff    <= '0;
         count_ff       <= '0;
         marks_ff       <= '0;
      end else begin
         if (csr_we) window_size_ff <= csr_wdata;
         if (cmd.commit) begin
            base_ff     <= base_in;
            next_seq_ff <= next_seq_in;
            count_ff    <= count_in;
            marks_ff    <= marks_in;
         end
      end
   end

endmodule

@@ rtl/selective_repeat_sender_window.sv @@
// Top level of the selective-repeat ARQ sender window.
// Each transaction is captured into the request register, then evaluated and
// committed to the result register once the output is free; a new event is
// accepted only after the capture/commit controller has committed the last.
// The result register lets a new request be accepted while a result waits.
// Synchronous active-high reset empties the window and sets window_size to 3.
`timescale 1ns / 1ps
module selective_repeat_sender_window (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  srsw_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output srsw_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_wdata
);
   import srsw_pkg::*;

   cmd_type cmd;

   srsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   srsw_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/sv/srsw_window_checker.sv @@
// Checker for the selective-repeat sender window: predicts each result and compares it.
`timescale 1ns / 1ps
module srsw_window_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  srsw_pkg::req_type         req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  srsw_pkg::rsp_type         rsp_data,
   input  logic                      csr_we,
   input  logic [2:0]                csr_wdata,
   output int                        failures,
   output int                        pending,
   output logic [srsw_pkg::SEQ_W-1:0] base_hint
);
   import srsw_pkg::*;

   localparam int EXPECT_DEPTH = 8;

   logic [WS_W-1:0]       window_size;
   logic [SEQ_W-1:0]      window_base;
   logic [SEQ_W-1:0]      next_seq;
   logic [CNT_W-1:0]      in_flight;
   logic [MAX_WINDOW-1:0] acked;
   rsp_type               expected_rsp[EXPECT_DEPTH];
   logic [2:0]            expect_wr;
   logic [2:0]            expect_rd;
   int                    expect_count;
   int                    mismatch_count = 0;

   assign failures = mismatch_count;

   // A window size of zero behaves as one, and anything above the maximum is clamped.
   function automatic int effective_window();
      if (window_size == '0) return 1;
      if (window_size > MAX_WINDOW) return MAX_WINDOW;
      return int'(window_size);
   endfunction

   function automatic rsp_type predict_window_event(input req_type item);
      rsp_type          result;
      logic [SEQ_W-1:0] offset;
      logic             outstanding;
      int               slide;
      result = '0;
      result.seq_out = item.seq_num;
      offset = item.seq_num - window_base;
      outstanding = (offset < in_flight) && (offset < MAX_WINDOW);
      case (item.func)
         FUNC_SEND: begin
            result.seq_out = next_seq;
            if (in_flight >= effective_window()) begin
               result.action = ACT_REFUSED;
            end else begin
               result.action = ACT_TRANSMIT;
               result.timer_start = 1'b1;
               next_seq = next_seq + 3'd1;
               in_flight = in_flight + 3'd1;
            end
         end
         FUNC_ACK: begin
            if (item.checksum_ok && outstanding) begin
               result.action = ACT_ACK_TAKEN;
               result.timer_stop = 1'b1;
               acked[offset[OFF_W-1:0]] = 1'b1;
               // The base slides over every leading slot that has been acknowledged.
               slide = 0;
               while (slide < in_flight && slide < MAX_WINDOW && acked[slide[OFF_W-1:0]])
                  slide++;
               acked = acked >> slide;
               window_base = window_base + slide[SEQ_W-1:0];
               in_flight = in_flight - slide[CNT_W-1:0];
               result.slots_freed = slide[CNT_W-1:0];
            end else begin
               result.action = ACT_ACK_IGNORE;
            end
         end
         FUNC_TIMEOUT: begin
            result.timer_stop = 1'b1;
            if (outstanding) begin
               result.action = ACT_RETRANSMIT;
               result.timer_start = 1'b1;
            end else begin
               result.action = ACT_TIMEOUT_ERR;
            end
         end
         default: begin
            result.action = ACT_ACK_IGNORE;
         end
      endcase
      result.window_full = (in_flight >= effective_window());
      return result;
   endfunction

   task automatic check_field(input string name, input logic [3:0] expected,
                              input logic [3:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         window_size = WINDOW_SIZE_RESET;
         window_base = '0;
         next_seq = '0;
         in_flight = '0;
         acked = '0;
         expect_wr = '0;
         expect_rd = '0;
         expect_count = 0;
      end else begin
         if (csr_we) window_size = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (expect_count == 0) begin
               $display("%0t: unexpected result, expected none, got action %0d seq %0d",
                        $time, rsp_data.action, rsp_data.seq_out);
               mismatch_count++;
            end else begin
               want = expected_rsp[expect_rd];
               expect_rd = expect_rd + 3'd1;
               expect_count--;
               check_field("action", 4'(want.action), 4'(rsp_data.action));
               check_field("seq_out", 4'(want.seq_out), 4'(rsp_data.seq_out));
               check_field("timer_start", 4'(want.timer_start), 4'(rsp_data.timer_start));
               check_field("timer_stop", 4'(want.timer_stop), 4'(rsp_data.timer_stop));
               check_field("slots_freed", 4'(want.slots_freed), 4'(rsp_data.slots_freed));
               check_field("window_full", 4'(want.window_full), 4'(rsp_data.window_full));
            end
         end
         if (req_valid && req_ready) begin
            if (expect_count == EXPECT_DEPTH) begin
               $display("%0t: too many transactions in flight, expected at most %0d, got %0d",
                        $time, EXPECT_DEPTH, expect_count + 1);
               mismatch_count++;
            end else begin
               expected_rsp[expect_wr] = predict_window_event(req_data);
               expect_wr = expect_wr + 3'd1;
               expect_count++;
            end
         end
      end
      pending <= expect_count;
      base_hint <= window_base;
   end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the sender window testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps
module testbench;
   import srsw_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 150;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we = 1'b0;
   logic [2:0]       csr_wdata = '0;
   int               failures;
   int               pending;
   logic [SEQ_W-1:0] base_hint;
   logic [7:0]       stall_phase = '0;
   int               burst_left = 1;

   always #6 clock = ~clock;

   selective_repeat_sender_window uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   srsw_window_checker window_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending),
      .base_hint (base_hint)
   );

   // The receiver cycles through always ready, coin flips, one in four, and long stalls.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      case (stall_phase[7:6])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2'd2: rsp_ready <= (stall_phase[1:0] == 2'd0);
         default: rsp_ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   function automatic req_type make_event(input logic [1:0] func, input logic [2:0] seq,
                                          input logic ok);
      req_type item;
      item.func = func;
      item.seq_num = seq;
      item.checksum_ok = ok;
      return item;
   endfunction

   // Most numbers land near the current base so that acks and timeouts hit the window.
   function automatic req_type random_event();
      req_type item;
      int      pick;
      pick = $urandom_range(0, 99);
      item.checksum_ok = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 9) == 0) item.seq_num = 3'($urandom);
      else item.seq_num = base_hint + 3'($urandom_range(0, 4));
      if (pick < 40) item.func = FUNC_SEND;
      else if (pick < 80) item.func = FUNC_ACK;
      else if (pick < 96) item.func = FUNC_TIMEOUT;
      else item.func = FUNC_UNUSED;
      return item;
   endfunction

   // Returns at the edge where the transaction is accepted, with valid still high.
   task automatic post_event(input req_type item);
      req_data <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic post_paced(input req_type item);
      int gap;
      post_event(item);
      burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic program_window(input logic [2:0] value);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run did not finish in time", $time);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [2:0] size_choice;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Default window of three: events on an empty window, then fill it past full.
      post_event(make_event(FUNC_TIMEOUT, 3'd0, 1'b1));
      post_event(make_event(FUNC_ACK, 3'd0, 1'b1));
      post_event(make_event(FUNC_UNUSED, 3'd7, 1'b1));
      repeat (4) post_event(make_event(FUNC_SEND, 3'd0, 1'b0));
      // Out-of-order and duplicate acks, a bad checksum, a retransmit, then the remaining acks.
      post_event(make_event(FUNC_ACK, 3'd1, 1'b1));
      post_event(make_event(FUNC_ACK, 3'd1, 1'b1));
      post_event(make_event(FUNC_ACK, 3'd2, 1'b0));
      post_event(make_event(FUNC_TIMEOUT, 3'd1, 1'b0));
      post_event(make_event(FUNC_ACK, 3'd0, 1'b1));
      post_event(make_event(FUNC_ACK, 3'd2, 1'b1));

      // Widest window, acknowledged in reverse so the last ack frees all four slots.
      program_window(3'd4);
      repeat (4) post_event(make_event(FUNC_SEND, 3'd7, 1'b1));
      post_event(make_event(FUNC_ACK, 3'd6, 1'b1));
      post_event(make_event(FUNC_ACK, 3'd5, 1'b1));
      post_event(make_event(FUNC_ACK, 3'd4, 1'b1));
      post_event(make_event(FUNC_ACK, 3'd3, 1'b1));

      // Out-of-range sizes, then a window shrunk below what is outstanding.
      program_window(3'd0);
      repeat (2) post_event(make_event(FUNC_SEND, 3'd0, 1'b0));
      program_window(3'd7);
      post_event(make_event(FUNC_SEND, 3'd0, 1'b0));
      program_window(3'd1);
      post_event(make_event(FUNC_SEND, 3'd0, 1'b0));
      post_event(make_event(FUNC_TIMEOUT, 3'd5, 1'b0));

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: size_choice = 3'd4;
            1: size_choice = 3'd1;
            2: size_choice = 3'd3;
            default: size_choice = 3'($urandom_range(0, 7));
         endcase
         program_window(size_choice);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) post_paced(random_event());
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/srsw_pkg.sv
rtl/srsw_ctrl.sv
rtl/srsw_dpath.sv
rtl/selective_repeat_sender_window.sv
tb/sv/srsw_window_checker.sv
tb/sv/testbench.sv
